// ===== src/wdbt_pkg.sv =====
// ----------------------------------------------------------------------------
// wdbt_pkg
// Shared widths, constants, types and calendar tables for the whole-days
// timestamp difference block.
// ----------------------------------------------------------------------------
package wdbt_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SEC_W    = 6;

    localparam int ELAPSED_W = 22;
    localparam int DAYNUM_W  = 23;
    localparam int TOD_W     = 17;
    localparam int PCORR_W   = 12;
    localparam int EXTRA_W   = 9;
    localparam int CENT_W    = 8;
    localparam int DBEFORE_W = 9;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every 14-bit x.
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = YEAR_W + 13;

    localparam int DAYS_PER_YEAR = 365;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int CENTURY       = 100;
    localparam int MONTH_FEB     = 2;
    localparam int MONTH_DEC     = 12;
    localparam int MAX_HOUR      = 23;
    localparam int MAX_MINUTE    = 59;
    localparam int FEB_COMMON    = 28;

    localparam logic [ELAPSED_W-1:0] DAYS_MAX = {ELAPSED_W{1'b1}};

    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SEC_W-1:0]    sec;
    } t_stamp;

    // Days in the months before the given month, in a common year.
    function automatic logic [DBEFORE_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DBEFORE_W-1:0] v;
        unique case (m)
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Length of the given month; February follows the leap flag.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic               leap);
        logic [DAY_W-1:0] v;
        unique case (m)
            4'd2:                 v = leap ? 5'(FEB_COMMON + 1) : 5'(FEB_COMMON);
            4'd4, 4'd6, 4'd9, 4'd11: v = 5'd30;
            default:              v = 5'd31;
        endcase
        return v;
    endfunction

endpackage

// ===== src/wdbt_in_if.sv =====
// ----------------------------------------------------------------------------
// wdbt_in_if
// Request channel: a pair of timestamps with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wdbt_in_if;
    logic                           valid;
    logic                           ready;
    logic [wdbt_pkg::DAY_W-1:0]     first_day;
    logic [wdbt_pkg::MONTH_W-1:0]   first_month;
    logic [wdbt_pkg::YEAR_W-1:0]    first_year;
    logic [wdbt_pkg::HOUR_W-1:0]    first_hour;
    logic [wdbt_pkg::MINUTE_W-1:0]  first_minute;
    logic [wdbt_pkg::SEC_W-1:0]     first_second;
    logic [wdbt_pkg::DAY_W-1:0]     second_day;
    logic [wdbt_pkg::MONTH_W-1:0]   second_month;
    logic [wdbt_pkg::YEAR_W-1:0]    second_year;
    logic [wdbt_pkg::HOUR_W-1:0]    second_hour;
    logic [wdbt_pkg::MINUTE_W-1:0]  second_minute;
    logic [wdbt_pkg::SEC_W-1:0]     second_sec;

    modport source (
        output valid, first_day, first_month, first_year, first_hour,
               first_minute, first_second, second_day, second_month,
               second_year, second_hour, second_minute, second_sec,
        input  ready
    );
    modport sink (
        input  valid, first_day, first_month, first_year, first_hour,
               first_minute, first_second, second_day, second_month,
               second_year, second_hour, second_minute, second_sec,
        output ready
    );
endinterface

// ===== src/wdbt_out_if.sv =====
// ----------------------------------------------------------------------------
// wdbt_out_if
// Result channel: elapsed whole days and validity flags, valid/ready.
// ----------------------------------------------------------------------------
interface wdbt_out_if;
    logic                            valid;
    logic                            ready;
    logic [wdbt_pkg::ELAPSED_W-1:0]  elapsed_days;
    logic                            first_date_ok;
    logic                            first_clock_ok;
    logic                            second_date_ok;
    logic                            second_clock_ok;

    modport source (
        output valid, elapsed_days, first_date_ok, first_clock_ok,
               second_date_ok, second_clock_ok,
        input  ready
    );
    modport sink (
        input  valid, elapsed_days, first_date_ok, first_clock_ok,
               second_date_ok, second_clock_ok,
        output ready
    );
endinterface

// ===== src/wdbt_stamp.sv =====
// ----------------------------------------------------------------------------
// wdbt_stamp
// Three-stage pipeline turning one timestamp into its Gregorian day number,
// its time of day in seconds and its validity flags.
// ----------------------------------------------------------------------------
module wdbt_stamp (
    input  logic                             i_clk,
    input  logic [2:0]                       i_en,
    input  wdbt_pkg::t_stamp                 i_stamp,
    output logic [wdbt_pkg::DAYNUM_W-1:0]    o_num,
    output logic [wdbt_pkg::TOD_W-1:0]       o_tod,
    output logic                             o_date_ok,
    output logic                             o_clock_ok
);

    // Stage A: century quotients, time of day, clock check, month offset.
    logic [wdbt_pkg::DAY_W-1:0]     r_a_day;
    logic [wdbt_pkg::MONTH_W-1:0]   r_a_month;
    logic [wdbt_pkg::YEAR_W-1:0]    r_a_year;
    logic [wdbt_pkg::YEAR_W-1:0]    r_a_prev;
    logic [wdbt_pkg::CENT_W-1:0]    r_a_qy;
    logic [wdbt_pkg::CENT_W-1:0]    r_a_qp;
    logic [wdbt_pkg::TOD_W-1:0]     r_a_tod;
    logic                           r_a_clk_ok;
    logic [wdbt_pkg::DBEFORE_W-1:0] r_a_dbefore;

    logic [wdbt_pkg::YEAR_W-1:0]    n_a_prev;
    logic [wdbt_pkg::PROD_W-1:0]    prod_y;
    logic [wdbt_pkg::PROD_W-1:0]    prod_p;
    logic [wdbt_pkg::TOD_W-1:0]     n_a_tod;
    logic                           n_a_clk_ok;

    always_comb begin
        n_a_prev = i_stamp.year - wdbt_pkg::YEAR_W'(1);
        prod_y   = wdbt_pkg::PROD_W'(i_stamp.year) * wdbt_pkg::PROD_W'(wdbt_pkg::RECIP_100);
        prod_p   = wdbt_pkg::PROD_W'(n_a_prev) * wdbt_pkg::PROD_W'(wdbt_pkg::RECIP_100);
        n_a_tod  = wdbt_pkg::TOD_W'(i_stamp.hour) * wdbt_pkg::TOD_W'(wdbt_pkg::SECS_PER_HOUR)
                 + wdbt_pkg::TOD_W'(i_stamp.minute) * wdbt_pkg::TOD_W'(wdbt_pkg::SECS_PER_MIN)
                 + wdbt_pkg::TOD_W'(i_stamp.sec);
        n_a_clk_ok = (i_stamp.hour <= wdbt_pkg::HOUR_W'(wdbt_pkg::MAX_HOUR))
                  && (i_stamp.minute <= wdbt_pkg::MINUTE_W'(wdbt_pkg::MAX_MINUTE))
                  && (i_stamp.sec <= wdbt_pkg::SEC_W'(wdbt_pkg::MAX_MINUTE));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_day     <= i_stamp.day;
            r_a_month   <= i_stamp.month;
            r_a_year    <= i_stamp.year;
            r_a_prev    <= n_a_prev;
            r_a_qy      <= prod_y[wdbt_pkg::RECIP_SHIFT +: wdbt_pkg::CENT_W];
            r_a_qp      <= prod_p[wdbt_pkg::RECIP_SHIFT +: wdbt_pkg::CENT_W];
            r_a_tod     <= n_a_tod;
            r_a_clk_ok  <= n_a_clk_ok;
            r_a_dbefore <= wdbt_pkg::days_before(i_stamp.month);
        end
    end

    // Stage B: leap rule, date check, whole-year days, leap corrections and day of year.
    logic [wdbt_pkg::DAYNUM_W-1:0] r_b_p365;
    logic [wdbt_pkg::PCORR_W-1:0]  r_b_pcorr;
    logic [wdbt_pkg::EXTRA_W-1:0]  r_b_extra;
    logic [wdbt_pkg::TOD_W-1:0]    r_b_tod;
    logic                          r_b_date_ok;
    logic                          r_b_clk_ok;

    logic                          cent_year;
    logic                          leap;
    logic                          n_b_date_ok;
    logic [wdbt_pkg::PCORR_W-1:0]  n_b_pcorr;
    logic [wdbt_pkg::EXTRA_W-1:0]  n_b_extra;

    always_comb begin
        cent_year = (wdbt_pkg::YEAR_W'(r_a_qy) * wdbt_pkg::YEAR_W'(wdbt_pkg::CENTURY))
                    == r_a_year;
        // Divisible by 400 is a century year whose century count divides by 4.
        leap = (r_a_year[1:0] == 2'b00) && (!cent_year || (r_a_qy[1:0] == 2'b00));
        n_b_date_ok = (r_a_day != '0) && (r_a_month != '0)
                   && (r_a_month <= wdbt_pkg::MONTH_W'(wdbt_pkg::MONTH_DEC))
                   && (r_a_year != '0)
                   && (r_a_day <= wdbt_pkg::month_len(r_a_month, leap));
        n_b_pcorr = wdbt_pkg::PCORR_W'(r_a_prev >> 2) + wdbt_pkg::PCORR_W'(r_a_qp >> 2)
                  - wdbt_pkg::PCORR_W'(r_a_qp);
        n_b_extra = r_a_dbefore + wdbt_pkg::EXTRA_W'(r_a_day)
                  + wdbt_pkg::EXTRA_W'(leap
                        && (r_a_month > wdbt_pkg::MONTH_W'(wdbt_pkg::MONTH_FEB)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_b_p365    <= wdbt_pkg::DAYNUM_W'(r_a_prev)
                         * wdbt_pkg::DAYNUM_W'(wdbt_pkg::DAYS_PER_YEAR);
            r_b_pcorr   <= n_b_pcorr;
            r_b_extra   <= n_b_extra;
            r_b_tod     <= r_a_tod;
            r_b_date_ok <= n_b_date_ok;
            r_b_clk_ok  <= r_a_clk_ok;
        end
    end

    // Stage C: final day number.
    logic [wdbt_pkg::DAYNUM_W-1:0] r_c_num;
    logic [wdbt_pkg::TOD_W-1:0]    r_c_tod;
    logic                          r_c_date_ok;
    logic                          r_c_clk_ok;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_c_num     <= r_b_p365 + wdbt_pkg::DAYNUM_W'(r_b_pcorr)
                         + wdbt_pkg::DAYNUM_W'(r_b_extra);
            r_c_tod     <= r_b_tod;
            r_c_date_ok <= r_b_date_ok;
            r_c_clk_ok  <= r_b_clk_ok;
        end
    end

    assign o_num      = r_c_num;
    assign o_tod      = r_c_tod;
    assign o_date_ok  = r_c_date_ok;
    assign o_clock_ok = r_c_clk_ok;

endmodule

// ===== src/whole_days_between_timestamps.sv =====
// ----------------------------------------------------------------------------
// whole_days_between_timestamps
// Absolute number of whole days between two timestamps, with validity flags.
// ----------------------------------------------------------------------------
// Usage:
// A pair of timestamps arrives on i_req; the transfer takes place at a rising
// edge where valid and ready are both high. Each pair gives exactly one
// result on o_rsp, in order, carrying the whole-day count and four flags
// that say whether each date and each time of day is valid. The count is 0
// whenever any flag is low, 0 for two timestamps on the same calendar day,
// and saturates at the largest value of its 22-bit field.
// The datapath is a five-stage pipeline: three stages per timestamp build
// the day number and the time of day, one stage compares and subtracts, and
// the last stage applies the partial-day correction and holds the result.
// It takes one pair per cycle, except while the whole pipeline is full and
// the receiver is stalling.
// Each stage has its own valid bit and advances when it is empty or when the
// stage after it advances, so a stalled receiver holds only the stages that
// are full; empty stages upstream keep taking transfers until the pipeline
// fills, and nothing is lost or repeated. A synchronous reset clears all
// valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module whole_days_between_timestamps (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wdbt_in_if.sink    i_req,
    wdbt_out_if.source o_rsp
);

    localparam int NSTAGE = 5;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] en;

    // A stage advances when it is empty or when the next stage advances.
    always_comb begin
        en[NSTAGE-1] = !r_vld[NSTAGE-1] || o_rsp.ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_req.ready = en[0];

    wdbt_pkg::t_stamp stamp_a;
    wdbt_pkg::t_stamp stamp_b;

    always_comb begin
        stamp_a.day    = i_req.first_day;
        stamp_a.month  = i_req.first_month;
        stamp_a.year   = i_req.first_year;
        stamp_a.hour   = i_req.first_hour;
        stamp_a.minute = i_req.first_minute;
        stamp_a.sec    = i_req.first_second;
        stamp_b.day    = i_req.second_day;
        stamp_b.month  = i_req.second_month;
        stamp_b.year   = i_req.second_year;
        stamp_b.hour   = i_req.second_hour;
        stamp_b.minute = i_req.second_minute;
        stamp_b.sec    = i_req.second_sec;
    end

    logic [wdbt_pkg::DAYNUM_W-1:0] num_a;
    logic [wdbt_pkg::DAYNUM_W-1:0] num_b;
    logic [wdbt_pkg::TOD_W-1:0]    tod_a;
    logic [wdbt_pkg::TOD_W-1:0]    tod_b;
    logic                          date_ok_a;
    logic                          date_ok_b;
    logic                          clock_ok_a;
    logic                          clock_ok_b;

    // The first three stages run once for each timestamp in parallel.
    wdbt_stamp u_stamp_a (
        .i_clk      (i_clk),
        .i_en       (en[2:0]),
        .i_stamp    (stamp_a),
        .o_num      (num_a),
        .o_tod      (tod_a),
        .o_date_ok  (date_ok_a),
        .o_clock_ok (clock_ok_a)
    );

    wdbt_stamp u_stamp_b (
        .i_clk      (i_clk),
        .i_en       (en[2:0]),
        .i_stamp    (stamp_b),
        .o_num      (num_b),
        .o_tod      (tod_b),
        .o_date_ok  (date_ok_b),
        .o_clock_ok (clock_ok_b)
    );

    // Stage D: order the day numbers, take the difference and decide whether
    // the later timestamp falls earlier in its day than the earlier one.
    logic [wdbt_pkg::DAYNUM_W-1:0] r_d_diff;
    logic                          r_d_borrow;
    logic                          r_d_all_ok;
    logic [3:0]                    r_d_flags;

    logic                          a_later;
    logic                          b_later;
    logic [wdbt_pkg::DAYNUM_W-1:0] n_d_diff;
    logic                          n_d_borrow;

    always_comb begin
        a_later    = num_a > num_b;
        b_later    = num_b > num_a;
        n_d_diff   = a_later ? (num_a - num_b) : (num_b - num_a);
        // On the same day both flags are low and the difference is zero.
        n_d_borrow = (a_later && (tod_a < tod_b)) || (b_later && (tod_b < tod_a));
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_d_diff   <= n_d_diff;
            r_d_borrow <= n_d_borrow;
            r_d_all_ok <= date_ok_a && clock_ok_a && date_ok_b && clock_ok_b;
            r_d_flags  <= {date_ok_a, clock_ok_a, date_ok_b, clock_ok_b};
        end
    end

    // Stage E: partial-day correction, saturation and the invalid-input rule.
    // This stage is the output register.
    logic [wdbt_pkg::ELAPSED_W-1:0] r_e_days;
    logic [3:0]                     r_e_flags;

    logic [wdbt_pkg::DAYNUM_W-1:0]  whole;
    logic [wdbt_pkg::ELAPSED_W-1:0] n_e_days;

    always_comb begin
        whole = r_d_diff - wdbt_pkg::DAYNUM_W'(r_d_borrow);
        if (!r_d_all_ok) begin
            n_e_days = '0;
        end else if (whole > wdbt_pkg::DAYNUM_W'(wdbt_pkg::DAYS_MAX)) begin
            n_e_days = wdbt_pkg::DAYS_MAX;
        end else begin
            n_e_days = whole[wdbt_pkg::ELAPSED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_e_days  <= n_e_days;
            r_e_flags <= r_d_flags;
        end
    end

    assign o_rsp.valid           = r_vld[NSTAGE-1];
    assign o_rsp.elapsed_days    = r_e_days;
    assign o_rsp.first_date_ok   = r_e_flags[3];
    assign o_rsp.first_clock_ok  = r_e_flags[2];
    assign o_rsp.second_date_ok  = r_e_flags[1];
    assign o_rsp.second_clock_ok = r_e_flags[0];

    // The input side only pushes back when the whole pipeline is full and
    // the receiver is stalling.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (&r_vld) && !o_rsp.ready)
        else $error("input stalled while the pipeline had room");

    // Any invalid field forces a zero day count.
    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !(o_rsp.first_date_ok && o_rsp.first_clock_ok
                         && o_rsp.second_date_ok && o_rsp.second_clock_ok)
        |-> o_rsp.elapsed_days == '0)
        else $error("non-zero day count with an invalid timestamp");

    // A transfer into an empty pipeline reaches the output after passing through every stage.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && (r_vld == '0) |-> ##5 o_rsp.valid)
        else $error("result did not appear after the pipeline latency");

endmodule
